FILE: rtl/bia_pkg.sv
// Shared constants, codes and a helper function for the bitmap ID allocator.
// No dependencies; bia_map_ram and bitmap_id_allocator import it.
package bia_pkg;

    localparam int ID_CAPACITY_DEF = 1024;
    localparam int HANDLE_BITS_DEF = 32;

    localparam int ID_SPACE = 1024;
    localparam int ID_W     = 10;
    localparam int HANDLE_W = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int MAP_W    = 64;
    localparam int BIT_W    = 6;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_LOOKUP
    } state_t;

    function automatic logic [BIT_W-1:0] lowest_zero(input logic [MAP_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/bia_map_ram.sv
// Used-bit map memory: 64-bit words, registered read.
// Per-word valid bits make unwritten words read as zero. Depends on bia_pkg.
module bia_map_ram
    import bia_pkg::*;
#(
    parameter int AW = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [MAP_W-1:0] wr_data,
    output logic [MAP_W-1:0] rd_data
);

    localparam int DEPTH = 1 << AW;

    logic [MAP_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [MAP_W-1:0] q_reg;
    logic             q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

FILE: rtl/bia_owner_ram.sv
// Owner handle memory, one entry per ID, registered read.
// Contents are undefined until written. No dependencies.
module bia_owner_ram #(
    parameter int AW = 10,
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg <= mem[rd_addr];
    end

    assign rd_data = q_reg;

endmodule

FILE: rtl/bitmap_id_allocator.sv
// Bitmap ID allocator: top level with the command sequencer.
// Release and lookup pass through a single S_UPDATE or S_LOOKUP state; allocate
// scans map words one per cycle from the hint, each at most once, in S_SCAN.
// busy is high from the accepting edge until the edge that raises done; the
// receiver cannot stall. Async active-low reset clears the map and the hint.
// Depends on bia_pkg, bia_map_ram and bia_owner_ram.
module bitmap_id_allocator
    import bia_pkg::*;
#(
    parameter int ID_CAPACITY = ID_CAPACITY_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    command,
    input  logic [ID_W-1:0]     id_in,
    input  logic [HANDLE_W-1:0] owner_handle,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     id_out,
    output logic [HANDLE_W-1:0] handle_out
);

    localparam int ID_LIMIT   = (ID_CAPACITY < ID_SPACE) ? ID_CAPACITY : ID_SPACE;
    localparam int WORD_COUNT = (ID_LIMIT + MAP_W - 1) / MAP_W;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int OWN_AW     = $clog2(ID_LIMIT);
    localparam int STORE_BITS = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int REM        = ID_LIMIT % MAP_W;
    localparam logic [MAP_W-1:0] LAST_MASK =
        (REM == 0) ? {MAP_W{1'b1}} : ((64'd1 << REM) - 64'd1);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_COUNT - 1);
    localparam logic [WORD_AW-1:0] WORD_ONE  = WORD_AW'(1);
    localparam logic [ID_W:0]      ID_LIMIT_V = (ID_W + 1)'(ID_LIMIT);

    state_t state_reg, state_next;

    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [STORE_BITS-1:0] handle_reg, handle_next;
    logic [WORD_AW-1:0]    chk_word_reg, chk_word_next;
    logic [WORD_AW-1:0]    cnt_reg, cnt_next;
    logic [WORD_AW-1:0]    hint_reg, hint_next;
    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [ID_W-1:0]       id_out_reg, id_out_next;
    logic [HANDLE_W-1:0]   handle_out_reg, handle_out_next;

    logic [WORD_AW-1:0]    map_rd_addr, map_wr_addr;
    logic                  map_wr_en;
    logic [MAP_W-1:0]      map_wr_data, map_rdata;
    logic [OWN_AW-1:0]     own_rd_addr, own_wr_addr;
    logic                  own_wr_en;
    logic [STORE_BITS-1:0] own_rdata;

    logic [MAP_W-1:0]      scan_word;
    logic                  scan_hit;
    logic                  scan_last;
    logic [BIT_W-1:0]      bit_pos;
    logic [WORD_AW-1:0]    chk_succ;
    logic [ID_W-1:0]       found_id;
    logic                  id_in_range;
    logic                  id_present;

    bia_map_ram #(
        .AW (WORD_AW)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (map_rd_addr),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_data (map_rdata)
    );

    bia_owner_ram #(
        .AW (OWN_AW),
        .DW (STORE_BITS)
    ) u_owner (
        .clk     (clk),
        .rd_addr (own_rd_addr),
        .wr_en   (own_wr_en),
        .wr_addr (own_wr_addr),
        .wr_data (handle_reg),
        .rd_data (own_rdata)
    );

    assign scan_word   = map_rdata | ((chk_word_reg == LAST_WORD) ? ~LAST_MASK : '0);
    assign scan_hit    = ~(&scan_word);
    assign scan_last   = (cnt_reg == LAST_WORD);
    assign bit_pos     = lowest_zero(scan_word);
    assign chk_succ    = (chk_word_reg == LAST_WORD) ? '0 : chk_word_reg + WORD_ONE;
    assign found_id    = ID_W'({chk_word_reg, bit_pos});
    assign id_in_range = ({1'b0, id_reg} < ID_LIMIT_V);
    assign id_present  = id_in_range && map_rdata[id_reg[BIT_W-1:0]];
    assign own_wr_addr = found_id[OWN_AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_ALLOC)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (command == CMD_LOOKUP)
                    begin
                        state_next = S_LOOKUP;
                    end
                    else
                    begin
                        state_next = S_UPDATE;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_UPDATE: state_next = S_IDLE;
            S_LOOKUP: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        handle_next     = handle_reg;
        chk_word_next   = chk_word_reg;
        cnt_next        = cnt_reg;
        hint_next       = hint_reg;
        done_next       = 1'b0;
        status_next     = ST_OK;
        id_out_next     = '0;
        handle_out_next = '0;
        map_rd_addr     = chk_succ;
        map_wr_en       = 1'b0;
        map_wr_addr     = chk_word_reg;
        map_wr_data     = map_rdata;
        own_rd_addr     = id_in[OWN_AW-1:0];
        own_wr_en       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                map_rd_addr = (command == CMD_ALLOC) ? hint_reg : id_in[BIT_W +: WORD_AW];
                if (start)
                begin
                    cmd_next      = command;
                    id_next       = id_in;
                    handle_next   = owner_handle[STORE_BITS-1:0];
                    chk_word_next = hint_reg;
                    cnt_next      = '0;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    map_wr_en   = 1'b1;
                    map_wr_data = map_rdata | (64'd1 << bit_pos);
                    own_wr_en   = 1'b1;
                    hint_next   = chk_word_reg;
                    id_out_next = found_id;
                    done_next   = 1'b1;
                end
                else if (scan_last)
                begin
                    status_next = ST_FULL;
                    done_next   = 1'b1;
                end
                else
                begin
                    chk_word_next = chk_succ;
                    cnt_next      = cnt_reg + WORD_ONE;
                end
            end
            S_UPDATE:
            begin
                map_wr_en   = (cmd_reg == CMD_RELEASE) && id_in_range;
                map_wr_addr = id_reg[BIT_W +: WORD_AW];
                map_wr_data = map_rdata & ~(64'd1 << id_reg[BIT_W-1:0]);
                done_next   = 1'b1;
            end
            S_LOOKUP:
            begin
                status_next     = id_present ? ST_OK : ST_ABSENT;
                handle_out_next = id_present ? HANDLE_W'(own_rdata) : '0;
                done_next       = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hint_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        handle_reg     <= handle_next;
        chk_word_reg   <= chk_word_next;
        cnt_reg        <= cnt_next;
        status_reg     <= status_next;
        id_out_reg     <= id_out_next;
        handle_out_reg <= handle_out_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign id_out     = id_out_reg;
    assign handle_out = handle_out_reg;

endmodule
